// ===== rtl/isms_pkg.sv =====
// Shared types and defaults for the interval set merge/insert block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package isms_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam int DEFAULT_CODE_WIDTH  = 16;
   localparam int COMMAND_WIDTH       = 2;
   localparam int STATUS_WIDTH        = 2;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2
   } command_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_INVERTED = 2'd2,
      STAT_INDEX    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_ABSORB,
      ST_COMPACT,
      ST_READ
   } state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

// ===== rtl/isms_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on isms_pkg for widths and defaults.
`timescale 1ns / 1ps

interface isms_req_if import isms_pkg::*; #(
   parameter int CODE_WIDTH  = DEFAULT_CODE_WIDTH,
   parameter int INDEX_WIDTH = $clog2(DEFAULT_TABLE_DEPTH)
);
   logic                     valid;
   logic                     ready;
   logic [COMMAND_WIDTH-1:0] command;
   logic [CODE_WIDTH-1:0]    range_low;
   logic [CODE_WIDTH-1:0]    range_high;
   logic [INDEX_WIDTH-1:0]   entry_index;

   modport source (output valid, command, range_low, range_high, entry_index, input ready);
   modport sink   (input valid, command, range_low, range_high, entry_index, output ready);
endinterface

interface isms_rsp_if import isms_pkg::*; #(
   parameter int CODE_WIDTH  = DEFAULT_CODE_WIDTH,
   parameter int COUNT_WIDTH = $clog2(DEFAULT_TABLE_DEPTH + 1)
);
   logic                    valid;
   logic                    ready;
   logic [CODE_WIDTH-1:0]   entry_low;
   logic [CODE_WIDTH-1:0]   entry_high;
   logic [COUNT_WIDTH-1:0]  entry_count;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, entry_low, entry_high, entry_count, status, input ready);
   modport sink   (input valid, entry_low, entry_high, entry_count, status, output ready);
endinterface

// ===== rtl/isms_engine.sv =====
// Range table engine: table memory, entry count and the insert/read/clear sequencer.
// Depends on isms_pkg.
`timescale 1ns / 1ps

module isms_engine import isms_pkg::*; #(
   parameter int  TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int  CODE_WIDTH  = DEFAULT_CODE_WIDTH,
   localparam int IDX_W       = $clog2(TABLE_DEPTH),
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  command_type           cmd,
   input  logic [CODE_WIDTH-1:0] lo_i,
   input  logic [CODE_WIDTH-1:0] hi_i,
   input  logic [IDX_W-1:0]      idx_i,
   output eng_stat_type          stat,
   output logic [CODE_WIDTH-1:0] res_low,
   output logic [CODE_WIDTH-1:0] res_high,
   output logic [CNT_W-1:0]      res_count,
   output status_type            res_status
);

   localparam int CW = CODE_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
   localparam logic [CW:0]      ONE_WIDE  = (CW + 1)'(1);

   logic [2*CW-1:0] range_mem [TABLE_DEPTH];
   logic [2*CW-1:0] rdata_ff;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] newcnt_ff, newcnt_in;
   logic [CW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]   acc_lo_ff, acc_lo_in, acc_hi_ff, acc_hi_in;

   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic [2*CW-1:0]  wr_data;
   logic             done;

   logic [CW-1:0]    rd_b, rd_e;
   logic [CNT_W-1:0] ptr_nx, ptr_pv, cnt_m1;
   logic             ptr_lt_n, full;
   logic             c_end, c_before, c_adj, c_touch;
   logic             a_more, a_compact, s_last, k_last;

   assign rd_b     = rdata_ff[CW-1:0];
   assign rd_e     = rdata_ff[2*CW-1:CW];
   assign ptr_nx   = ptr_ff + ONE_CNT;
   assign ptr_pv   = ptr_ff - ONE_CNT;
   assign cnt_m1   = count_ff - ONE_CNT;
   assign ptr_lt_n = ptr_ff < count_ff;
   assign full     = count_ff == DEPTH_CNT;

   // adjacency tests run one bit wider than the code space
   assign c_end     = !ptr_lt_n;
   assign c_before  = hi_ff < rd_b;
   assign c_adj     = ({1'b0, hi_ff} + ONE_WIDE) == {1'b0, rd_b};
   assign c_touch   = {1'b0, lo_ff} <= ({1'b0, rd_e} + ONE_WIDE);
   assign a_more    = ptr_lt_n && ({1'b0, rd_b} <= ({1'b0, acc_hi_ff} + ONE_WIDE));
   assign a_compact = ptr_lt_n && (ptr_ff != (pos_ff + ONE_CNT));
   assign s_last    = ptr_ff == pos_ff;
   assign k_last    = ptr_nx == count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= range_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      newcnt_ff <= newcnt_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      acc_lo_ff <= acc_lo_in;
      acc_hi_ff <= acc_hi_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (cmd)
                  CMD_INSERT: state_in = (lo_i > hi_i) ? ST_IDLE : ST_SCAN;
                  CMD_READ:   state_in = ({1'b0, idx_i} < count_ff) ? ST_READ : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (c_end) begin
               state_in = ST_IDLE;
            end else if (c_before) begin
               state_in = (c_adj || full) ? ST_IDLE : ST_SHIFT;
            end else if (c_touch) begin
               state_in = ST_ABSORB;
            end
         end
         ST_SHIFT:   state_in = s_last ? ST_PLACE : ST_SHIFT;
         ST_PLACE:   state_in = ST_IDLE;
         ST_ABSORB: begin
            if (a_more) begin
               state_in = ST_ABSORB;
            end else begin
               state_in = a_compact ? ST_COMPACT : ST_IDLE;
            end
         end
         ST_COMPACT: state_in = k_last ? ST_IDLE : ST_COMPACT;
         ST_READ:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      pos_in     = pos_ff;
      newcnt_in  = newcnt_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      acc_lo_in  = acc_lo_ff;
      acc_hi_in  = acc_hi_ff;
      rd_addr    = ptr_nx[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = ptr_ff[IDX_W-1:0];
      wr_data    = {hi_ff, lo_ff};
      done       = 1'b0;
      res_low    = '0;
      res_high   = '0;
      res_status = STAT_OK;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (start) begin
               lo_in  = lo_i;
               hi_in  = hi_i;
               ptr_in = '0;
               case (cmd)
                  CMD_INSERT: begin
                     if (lo_i > hi_i) begin
                        done       = 1'b1;
                        res_status = STAT_INVERTED;
                     end
                  end
                  CMD_READ: begin
                     rd_addr = idx_i;
                     if (!({1'b0, idx_i} < count_ff)) begin
                        done       = 1'b1;
                        res_status = STAT_INDEX;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     done     = 1'b1;
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (c_end) begin
               done = 1'b1;
               if (full) begin
                  res_status = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + ONE_CNT;
               end
            end else if (c_before) begin
               if (c_adj) begin
                  wr_en   = 1'b1;
                  wr_data = {rd_e, lo_ff};
                  done    = 1'b1;
               end else if (full) begin
                  done       = 1'b1;
                  res_status = STAT_FULL;
               end else begin
                  pos_in  = ptr_ff;
                  ptr_in  = cnt_m1;
                  rd_addr = cnt_m1[IDX_W-1:0];
               end
            end else if (c_touch) begin
               pos_in    = ptr_ff;
               acc_lo_in = (lo_ff < rd_b) ? lo_ff : rd_b;
               acc_hi_in = (hi_ff > rd_e) ? hi_ff : rd_e;
               ptr_in    = ptr_nx;
            end else begin
               ptr_in = ptr_nx;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_nx[IDX_W-1:0];
            wr_data = rdata_ff;
            if (!s_last) begin
               ptr_in  = ptr_pv;
               rd_addr = ptr_pv[IDX_W-1:0];
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_W-1:0];
            count_in = count_ff + ONE_CNT;
            done     = 1'b1;
         end
         ST_ABSORB: begin
            if (a_more) begin
               acc_hi_in = (rd_e > acc_hi_ff) ? rd_e : acc_hi_ff;
               ptr_in    = ptr_nx;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = pos_ff[IDX_W-1:0];
               wr_data   = {acc_hi_ff, acc_lo_ff};
               newcnt_in = count_ff - (ptr_ff - pos_ff - ONE_CNT);
               if (a_compact) begin
                  pos_in  = pos_ff + ONE_CNT;
                  rd_addr = ptr_ff[IDX_W-1:0];
               end else begin
                  count_in = newcnt_in;
                  done     = 1'b1;
               end
            end
         end
         ST_COMPACT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_W-1:0];
            wr_data = rdata_ff;
            pos_in  = pos_ff + ONE_CNT;
            ptr_in  = ptr_nx;
            if (k_last) begin
               count_in = newcnt_ff;
               done     = 1'b1;
            end
         end
         ST_READ: begin
            res_low  = rd_b;
            res_high = rd_e;
            done     = 1'b1;
         end
         default: ;
      endcase
   end

   assign res_count = count_in;
   assign stat.idle = state_ff == ST_IDLE;
   assign stat.done = done;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("word started while sequencer busy");

   a_done_source: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff != ST_IDLE || start))
      else $error("result without a word in progress");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPACT |-> pos_ff < ptr_ff)
      else $error("compaction write not below read pointer");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (start && cmd == CMD_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !done) |=> $stable(count_ff))
      else $error("entry count changed without a result");

endmodule

// ===== rtl/interval_set_merge_insert_top.sv =====
// Top level of the interval set merge/insert block: handshakes and result register.
// Depends on isms_pkg, isms_req_if / isms_rsp_if and isms_engine.
//
//   channel  | dir | word
//   req_bus  | in  | command, range_low, range_high, entry_index
//   rsp_bus  | out | entry_low, entry_high, entry_count, status
//
// Clear, unused command, inverted insert and out-of-range read finish on acceptance;
// a read finishes in ST_READ. An insert scans the table, then appends, extends an
// adjacent entry, shifts and places, or absorbs and compacts.
// Reset clears the entry count; table contents stay undefined, no clearing pass.
// The result waits in an output register; a new word is taken once the sequencer
// is idle and that register drains or is taken in the same cycle.
`timescale 1ns / 1ps

module interval_set_merge_insert_top import isms_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int CODE_WIDTH  = DEFAULT_CODE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   isms_req_if.sink   req_bus,
   isms_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   eng_stat_type          eng_stat;
   logic                  accept;
   logic [CODE_WIDTH-1:0] res_low, res_high;
   logic [CNT_W-1:0]      res_count;
   status_type            res_status;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0] rsp_low_ff, rsp_high_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   status_type            rsp_status_ff;

   assign req_bus.ready = eng_stat.idle && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   isms_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CODE_WIDTH  (CODE_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .cmd        (command_type'(req_bus.command)),
      .lo_i       (req_bus.range_low),
      .hi_i       (req_bus.range_high),
      .idx_i      (req_bus.entry_index),
      .stat       (eng_stat),
      .res_low    (res_low),
      .res_high   (res_high),
      .res_count  (res_count),
      .res_status (res_status)
   );

   always_comb begin
      if (eng_stat.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_stat.done) begin
         rsp_low_ff    <= res_low;
         rsp_high_ff   <= res_high;
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.entry_low   = rsp_low_ff;
   assign rsp_bus.entry_high  = rsp_high_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.status      = rsp_status_ff;

endmodule
